// ===== rtl/bole_pkg.sv =====
package bole_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_INSERT_FRONT = 3'd0,
      KIND_INSERT_BACK  = 3'd1,
      KIND_REMOVE_FRONT = 3'd2,
      KIND_REMOVE_BACK  = 3'd3,
      KIND_FIND         = 3'd4,
      KIND_DELETE_AT    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_POP   = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_SHIFT = 4'b1000
   } state_type;

   // map a logical position onto the circular store
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W-1:0] pos);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(pos);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
   endfunction

endpackage

// ===== rtl/bounded_ordered_list_engine_unit.sv =====
// Bounded ordered list engine: a deque of signed values in a circular store
// with search and positional delete.
// Command channel: drive req_kind, req_item_value and req_target_position
// with start; the transfer happens at a clock edge where start is high and
// busy is low. Result channel: rsp_valid marks the single cycle in which the
// rsp_ ports hold one result; the receiver cannot stall it, so sample it then.
// Every command gives exactly one result.
// Result path for each command, from the accepting edge to rsp_valid:
//   insert, rejected commands, delete at the head: rsp_valid is high in the next cycle, busy stays low.
//   remove front/back: one read of the store's single read port, then ST_POP hands the entry out.
//   find: stops at the first match, or reports not found after the last entry;
//     one entry is read per cycle, reads pipelined against the compare.
//   delete at clamped position p > 0: each entry behind p is read and
//     written back one slot lower, one per cycle.
// A new command may be taken in the cycle its predecessor's result shows.
// Reset (synchronous, active high) empties the list at once; the store's
// contents are left as they are and never read before being written.
module bounded_ordered_list_engine_unit
   import bole_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_kind,
   input  logic signed [DATA_WIDTH-1:0] req_item_value,
   input  logic [IDX_W-1:0]             req_target_position,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic [IDX_W-1:0]             rsp_found_position,
   output logic [CNT_W-1:0]             rsp_entry_count,
   output logic                         rsp_list_empty
);

   // entry store: one write port, one registered read port
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;          // next position to read
   logic                  pend_ff, pend_in;        // rdata_ff holds a live read
   logic [CNT_W-1:0]      pend_idx_ff, pend_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_result_ff, rsp_result_in;
   logic [IDX_W-1:0]      rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  accept;
   logic                  is_full;
   logic                  is_empty;
   logic [CNT_W-1:0]      last_pos;
   logic [CNT_W-1:0]      del_pos;
   logic                  match;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign last_pos = count_ff - CNT_W'(1);
   // clamp the delete position to the last entry
   assign del_pos  = (CNT_W'(req_target_position) > last_pos) ?
                     last_pos : CNT_W'(req_target_position);
   assign match    = pend_ff && (rdata_ff == val_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_result_in = rsp_result_ff;
      rsp_found_in  = rsp_found_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in        = req_item_value;
               rsp_status_in = STATUS_DONE;
               rsp_result_in = '0;
               rsp_found_in  = '0;
               unique case (kind_type'(req_kind))
                  KIND_INSERT_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        head_in  = idx_dec(head_ff);
                        wr_en    = 1'b1;
                        wr_addr  = idx_dec(head_ff);
                        wr_data  = req_item_value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_INSERT_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = phys(head_ff, count_ff);
                        wr_data  = req_item_value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_REMOVE_FRONT: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // read the head now, hand it out next cycle
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        head_in  = idx_inc(head_ff);
                        count_in = last_pos;
                        state_in = ST_POP;
                     end
                  end
                  KIND_REMOVE_BACK: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = phys(head_ff, last_pos);
                        count_in = last_pos;
                        state_in = ST_POP;
                     end
                  end
                  KIND_FIND: begin
                     idx_in   = '0;
                     pend_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
                  KIND_DELETE_AT: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else if (del_pos == '0) begin
                        // deleting the head just advances it
                        rsp_valid_in = 1'b1;
                        head_in      = idx_inc(head_ff);
                        count_in     = last_pos;
                     end else begin
                        idx_in   = del_pos + CNT_W'(1);
                        pend_in  = 1'b0;
                        state_in = ST_SHIFT;
                     end
                  end
                  default: begin
                     // unused codes: report done, touch nothing
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_DONE;
            rsp_result_in = rdata_ff;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            if (match) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_found_in  = pend_idx_ff[IDX_W-1:0];
               pend_in       = 1'b0;
               state_in      = ST_IDLE;
            end else if (idx_ff >= count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
               pend_in       = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               rd_en       = 1'b1;
               rd_addr     = phys(head_ff, idx_ff);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               idx_in      = idx_ff + CNT_W'(1);
            end
         end
         ST_SHIFT: begin
            // write back the entry read last cycle one slot lower
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = phys(head_ff, pend_idx_ff);
               wr_data = rdata_ff;
            end
            if (idx_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = phys(head_ff, idx_ff);
               pend_in     = 1'b1;
               pend_idx_in = idx_ff - CNT_W'(1);
               idx_in      = idx_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_DONE;
                  count_in      = last_pos;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // every result carries the occupancy after its operation
      rsp_count_in = rsp_valid_in ? count_in : rsp_count_ff;
      rsp_empty_in = rsp_valid_in ? (count_in == '0) : rsp_empty_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_value   = rsp_result_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_list_empty     = rsp_empty_ff;

   // shift reads always run ahead of the write-back
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("store read and write hit the same entry");

   // a search leaves the list untouched
   a_scan_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> ($stable(count_ff) && $stable(head_ff)))
      else $error("list changed during find");

   // inserts answer in the next cycle
   a_insert_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_INSERT_FRONT || req_kind == KIND_INSERT_BACK))
      |=> rsp_valid)
      else $error("insert gave no result in the next cycle");

   // a pop always directly follows the accepted command
   a_pop_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> $past(accept))
      else $error("pop state entered without a command");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CNT_W'(DEPTH)))
      else $error("entry count beyond depth");

endmodule
